### hw/rtl/cht_pkg.sv
// chained hash table package: status codes, request kind and state enums, widths
// no dependencies
package cht_pkg;

    localparam int KEY_W = 31;
    localparam int PAY_W = 16;
    localparam int CFG_W = 9;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_WALK,
        S_CHECK,
        S_DONE
    } state_t;

endpackage

### hw/rtl/cht_if.sv
// valid/ready channel interfaces for the chained hash table
// depends on cht_pkg
interface cht_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [cht_pkg::KEY_W-1:0] key;
    logic [cht_pkg::PAY_W-1:0] payload;
    modport source (output valid, kind, key, payload, input ready);
    modport sink (input valid, kind, key, payload, output ready);
endinterface

interface cht_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [cht_pkg::PAY_W-1:0] payload_out;
    modport source (output valid, status, payload_out, input ready);
    modport sink (input valid, status, payload_out, output ready);
endinterface

interface cht_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cht_pkg::CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hw/rtl/cht_mod.sv
// restoring modulo unit: one quotient bit per cycle
// depends on cht_pkg
module cht_mod
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cht_pkg::KEY_W-1:0] dividend,
    input  logic [cht_pkg::CFG_W-1:0] divisor,
    output logic                      done,
    output logic [cht_pkg::CFG_W-1:0] remainder
);
    import cht_pkg::*;

    localparam int CNT_W = $clog2(KEY_W + 1);

    logic [KEY_W-1:0] sh_reg,  sh_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [CFG_W:0]   trial;

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, sh_reg[KEY_W-1]};
        if (start)
        begin
            sh_next   = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(KEY_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so one subtract suffices
            if (trial >= {1'b0, divisor})
                rem_next = CFG_W'(trial - {1'b0, divisor});
            else
                rem_next = CFG_W'(trial);
            sh_next  = {sh_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == CNT_W'(1)) && !start;
    assign remainder = rem_next;

endmodule

### hw/rtl/chained_hash_table.sv
// chained hash table top level: controller, bucket head and entry memories
// depends on cht_pkg, cht_if, cht_mod
//
// usage
//   req channel carries kind (0 lookup, 1 insert if absent), key, payload
//   rsp channel returns one transaction per request: status, payload_out
//   cfg channel writes bucket_count; 0 acts as 1, above BUCKETS acts as BUCKETS
// sequence
//   the key passes through the bit-serial modulo unit, the bucket head is
//   read, then each chain entry visited takes a walk and a check state;
//   a hit is filed from the check state, while a miss ends the walk in
//   the walk state and files its result in the done state
//   only one request is in flight; req.ready is high while idle with no
//   result pending, so the next request can be taken in the cycle after
//   the result has left
// reset
//   the head memory is swept clear after reset, one bucket per cycle;
//   no request is taken during the sweep (cfg writes are taken)
//   the entry memory is not cleared: only written entries are reachable
// stall
//   the result waits in the output register until rsp.ready; the next
//   request is taken only after the result has left
module chained_hash_table
#(
    parameter int BUCKETS = 256,
    parameter int ENTRIES = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    cht_req_if.sink   req,
    cht_rsp_if.source rsp,
    cht_cfg_if.sink   cfg
);
    import cht_pkg::*;

    localparam int BI_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EI_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LK_W = $clog2(ENTRIES + 1);      // link = index + 1, 0 null
    localparam int BC_W = $clog2(BUCKETS + 1);

    // memories
    logic [LK_W-1:0]  head_mem [BUCKETS];
    logic [KEY_W-1:0] ekey_mem [ENTRIES];
    logic [PAY_W-1:0] epay_mem [ENTRIES];
    logic [LK_W-1:0]  elnk_mem [ENTRIES];

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] bcnt_reg;
    logic [LK_W-1:0]  used_reg, used_next;
    logic [BC_W-1:0]  clr_reg;
    logic             clr_busy;

    logic             kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_reg;
    logic [BI_W-1:0]  bkt_reg, bkt_next;
    logic [LK_W-1:0]  link_reg, link_next;
    logic [LK_W-1:0]  hd_reg;          // head link at start of walk
    logic [LK_W-1:0]  steps_reg, steps_next;

    logic             ov_reg, ov_next;
    logic [1:0]       st_reg, st_next;
    logic [PAY_W-1:0] po_reg, po_next;

    logic [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0] rd_pay;
    logic [LK_W-1:0]  rd_lnk;
    logic [LK_W-1:0]  rd_head;

    logic             req_fire;
    logic             mod_done;
    logic [CFG_W-1:0] mod_rem;
    logic [CFG_W-1:0] act_bcnt;
    logic             head_we;
    logic             ent_we;
    logic [EI_W-1:0]  rd_idx;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !clr_busy && !ov_reg;
    assign cfg.ready = 1'b1;
    assign clr_busy  = (clr_reg != BC_W'(BUCKETS));

    // clamp bucket count into 1..BUCKETS
    always_comb
    begin
        if (bcnt_reg == '0)
            act_bcnt = CFG_W'(1);
        else if ({{(32-CFG_W){1'b0}}, bcnt_reg} > 32'(BUCKETS))
            act_bcnt = CFG_W'(BUCKETS);
        else
            act_bcnt = bcnt_reg;
    end

    cht_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_fire),
        .dividend  (req.key),
        .divisor   (act_bcnt),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // entry read address: index of link_next (walk follows link - 1)
    assign rd_idx = EI_W'(link_next - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        bkt_next   = bkt_reg;
        link_next  = link_reg;
        steps_next = steps_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        po_next    = po_reg;
        head_we    = 1'b0;
        ent_we     = 1'b0;
        if (ov_reg && rsp.ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    bkt_next   = BI_W'(mod_rem);
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                // head memory data valid now
                link_next  = rd_head;
                steps_next = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // entry address presented this cycle, data next
                if (link_reg == '0 || steps_reg == LK_W'(ENTRIES))
                begin
                    state_next = S_DONE;
                end
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_key == key_reg)
                begin
                    st_next    = ST_FOUND;
                    po_next    = rd_pay;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    link_next  = rd_lnk;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK;
                end
            end
            S_DONE:
            begin
                if (kind_reg == KIND_LOOKUP)
                begin
                    st_next = ST_NOT_FOUND;
                    po_next = '0;
                end
                else if (used_reg == LK_W'(ENTRIES))
                begin
                    st_next = ST_FULL;
                    po_next = '0;
                end
                else
                begin
                    head_we   = 1'b1;
                    ent_we    = 1'b1;
                    used_next = used_reg + 1'b1;
                    st_next   = ST_INSERTED;
                    po_next   = pay_reg;
                end
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            bcnt_reg  <= CFG_W'(BUCKETS);
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            if (cfg.valid)
                bcnt_reg <= cfg.data;
            if (clr_busy)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.key;
            pay_reg  <= req.payload;
        end
        bkt_reg   <= bkt_next;
        link_reg  <= link_next;
        steps_reg <= steps_next;
        st_reg    <= st_next;
        po_reg    <= po_next;
        if (state_reg == S_HEAD)
            hd_reg <= rd_head;
    end

    // bucket head memory: sweep clear after reset, insert writes new head
    always_ff @(posedge clk)
    begin
        if (clr_busy)
            head_mem[BI_W'(clr_reg)] <= '0;
        else if (head_we)
            head_mem[bkt_reg] <= used_reg + 1'b1;
        rd_head <= head_mem[bkt_next];
    end

    // entry memories: written once per insert at the allocation index
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ekey_mem[EI_W'(used_reg)] <= key_reg;
            epay_mem[EI_W'(used_reg)] <= pay_reg;
            elnk_mem[EI_W'(used_reg)] <= hd_reg;
        end
        rd_key <= ekey_mem[rd_idx];
        rd_pay <= epay_mem[rd_idx];
        rd_lnk <= elnk_mem[rd_idx];
    end

    assign rsp.valid       = ov_reg;
    assign rsp.status      = st_reg;
    assign rsp.payload_out = po_reg;

    // no request while a result is pending or during the clear sweep
    assert property (@(posedge clk) disable iff (!rst_n) req_fire |-> !ov_reg && !clr_busy)
        else $error("request taken while busy");
    // allocation count never exceeds the entry store
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= LK_W'(ENTRIES))
        else $error("entry count overflow");
    // count grows only on an insert result
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> ov_reg && st_reg == ST_INSERTED)
        else $error("allocation without insert");
    // not-found and full results carry a zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && (st_reg == ST_NOT_FOUND || st_reg == ST_FULL) |-> po_reg == '0)
        else $error("payload on miss");

endmodule
